[hdl/align_heading_steering_core_assert.svh]
// Assertion macros shared by the heading steering modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ALIGN_HEADING_STEERING_CORE_ASSERT_SVH
`define ALIGN_HEADING_STEERING_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ahs_pkg.sv]
// Types, constants and helper functions of the heading steering block.
// Used by every module of the block; depends on nothing.
package ahs_pkg;

  // Full and half turn in 1/128 degree, half turn in 1/32768 degree.
  localparam int FULL_TURN = 46080;
  localparam int HALF_TURN = 23040;
  localparam int Z_HALF    = 180 * 32768;

  // CORDIC word widths.
  localparam int CW = 28;
  localparam int ZW = 26;

  // Shared divider widths.
  localparam int DVD_W = 38;
  localparam int DVS_W = 20;
  localparam int DCNT_W = 6;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_TARGET_RADIUS = 3'd0,
    REG_SLOW_RADIUS   = 3'd1,
    REG_MAX_ROTATION  = 3'd2,
    REG_TIME_TO_TGT   = 3'd3,
    REG_MAX_ACCEL     = 3'd4
  } reg_idx_e;

  // Operand selection of the shared divider.
  typedef enum logic [1:0] {
    DIV_WANT = 2'd0,
    DIV_ANG  = 2'd1,
    DIV_HEAD = 2'd2
  } div_sel_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CORDIC, S_ERR, S_DECIDE, S_MULW, S_DIVW_S, S_DIVW_W, S_DIFF,
    S_DIVA_S, S_DIVA_W, S_SAT, S_HMUL, S_HADD, S_DIVH_S, S_DIVH_W, S_HWRAP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] self_x;
    logic signed [15:0] self_y;
    logic [15:0]        time_step;
  } in_t;

  typedef struct packed {
    logic signed [20:0] angular_out;
    logic signed [15:0] new_heading;
    logic               coincident;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     cordic;
    logic     calc_err;
    logic     ang_zero;
    logic     mul_want;
    logic     div_start;
    div_sel_e div_sel;
    logic     calc_diff;
    logic     sat;
    logic     head_mul;
    logic     head_add;
    logic     head_wrap;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cordic_last;
    logic coin;
    logic in_radius;
    logic full;
    logic div_busy;
  } sts_t;

  // atan(2^-i) in 1/32768 degree.
  function automatic logic [20:0] ahs_atan(input logic [4:0] i);
    logic [20:0] r;
    case (i)
      5'd0:  r = 21'd1474560;
      5'd1:  r = 21'd870484;
      5'd2:  r = 21'd459940;
      5'd3:  r = 21'd233473;
      5'd4:  r = 21'd117189;
      5'd5:  r = 21'd58653;
      5'd6:  r = 21'd29333;
      5'd7:  r = 21'd14667;
      5'd8:  r = 21'd7334;
      5'd9:  r = 21'd3667;
      5'd10: r = 21'd1833;
      5'd11: r = 21'd917;
      5'd12: r = 21'd458;
      5'd13: r = 21'd229;
      5'd14: r = 21'd115;
      5'd15: r = 21'd57;
      5'd16: r = 21'd29;
      5'd17: r = 21'd14;
      5'd18: r = 21'd7;
      5'd19: r = 21'd4;
      5'd20: r = 21'd2;
      5'd21: r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  // Folds an angle within one and a half turns into [-half, +half] turn.
  function automatic logic signed [15:0] ahs_wrap_half(input logic signed [18:0] a);
    logic signed [18:0] r;
    if (a > 19'sd23040) begin
      r = a - 19'sd46080;
    end else if (a < -19'sd23040) begin
      r = a + 19'sd46080;
    end else begin
      r = a;
    end
    return r[15:0];
  endfunction

endpackage

[hdl/ahs_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle, shared by the variable divisions.
// Depends on ahs_pkg for its widths.
module ahs_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ahs_pkg::DVD_W-1:0] dividend_i,
  input  logic [ahs_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [ahs_pkg::DVD_W-1:0] quot_o
);
  import ahs_pkg::*;

  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    rem_q, rem_d;
  logic [DVS_W:0]    trial;

  // One shift and trial subtraction per cycle; the dividend word fills with quotient bits.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

[hdl/ahs_datapath.sv]
// Datapath: configuration registers, CORDIC, error, rate and heading arithmetic.
// Depends on ahs_pkg and instantiates ahs_divider.
module ahs_datapath #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [19:0]       cfg_data_i,
  input  ahs_pkg::in_t      in_data_i,
  input  ahs_pkg::cmd_t     cmd_i,
  output ahs_pkg::sts_t     sts_o,
  output ahs_pkg::out_t     out_data_o
);
  import ahs_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Configuration registers.
  logic [14:0] tr_q, sl_q;
  logic [19:0] mr_q, macc_q;
  logic [15:0] ttt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q   <= 15'd128;
      sl_q   <= 15'd1280;
      mr_q   <= 20'd11520;
      ttt_q  <= 16'd6554;
      macc_q <= 20'd23040;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_RADIUS: tr_q   <= cfg_data_i[14:0];
        REG_SLOW_RADIUS:   sl_q   <= cfg_data_i[14:0];
        REG_MAX_ROTATION:  mr_q   <= cfg_data_i;
        REG_TIME_TO_TGT:   ttt_q  <= cfg_data_i[15:0];
        REG_MAX_ACCEL:     macc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Persistent steering state.
  logic signed [15:0] heading_q;
  logic signed [20:0] rate_q;

  // Working registers.
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic [IW-1:0]        idx_q;
  logic                 coin_q;
  logic [15:0]          ts_q;
  logic signed [15:0]   err_q;
  logic [14:0]          size_q;
  logic [37:0]          prod_q;
  logic                 dneg_q;
  logic [21:0]          dmag_q;
  logic signed [20:0]   ang_q;
  logic                 sneg_q;
  logic [23:0]          smag_q;
  out_t                 out_q;

  // Divider operands.
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs;
  logic             div_busy;
  logic             div_start, red_start;

  // The heading remainder runs on its own reducer, the other divisions on the divider.
  assign red_start = cmd_i.div_start && (cmd_i.div_sel == DIV_HEAD);
  assign div_start = cmd_i.div_start && (cmd_i.div_sel != DIV_HEAD);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_WANT: begin
        div_dvd = prod_q;
        div_dvs = {5'd0, sl_q};
      end
      DIV_ANG: begin
        div_dvd = {dmag_q, 16'd0};
        div_dvs = {4'd0, (ttt_q == 16'd0) ? 16'd1 : ttt_q};
      end
      default: begin
        div_dvd = prod_q;
        div_dvs = {5'd0, sl_q};
      end
    endcase
  end

  ahs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Heading magnitude modulo a full turn: compare and subtract 16, 8, 4, 2 and 1 turns,
  // one step per cycle; the magnitude stays below 32 turns.
  logic [23:0] red_q;
  logic [2:0]  red_cnt_q;
  logic        red_busy_q;
  logic [23:0] red_step;

  assign red_step = 24'(FULL_TURN) << (3'd4 - red_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_busy_q <= 1'b0;
      red_cnt_q  <= '0;
    end else if (red_start) begin
      red_busy_q <= 1'b1;
      red_cnt_q  <= '0;
    end else if (red_busy_q) begin
      red_cnt_q <= red_cnt_q + 1'b1;
      if (red_cnt_q == 3'd4) begin
        red_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (red_start) begin
      red_q <= smag_q;
    end else if (red_busy_q && (red_q >= red_step)) begin
      red_q <= red_q - red_step;
    end
  end

  // Word capture and CORDIC prerotation into the right half plane.
  logic signed [16:0]   dx, dy;
  logic signed [CW-1:0] x0, y0;
  assign dx = {in_data_i.target_x[15], in_data_i.target_x}
            - {in_data_i.self_x[15], in_data_i.self_x};
  assign dy = {in_data_i.target_y[15], in_data_i.target_y}
            - {in_data_i.self_y[15], in_data_i.self_y};
  assign x0 = {{(CW-25){dx[16]}}, dx, 8'd0};
  assign y0 = {{(CW-25){dy[16]}}, dy, 8'd0};

  // One CORDIC vectoring iteration.
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  assign xs = cx_q >>> idx_q;
  assign ys = cy_q >>> idx_q;
  assign at = $signed({{(ZW-21){1'b0}}, ahs_atan(5'(idx_q))});

  // Bearing rounded to 1/128 degree and the wrapped heading error.
  logic signed [ZW-1:0] bsum;
  logic signed [18:0]   bdiff, bmod;
  logic signed [15:0]   err_w;
  always_comb begin
    bsum  = cz_q + ZW'(128);
    bdiff = {bsum[ZW-1], bsum[ZW-1:8]} - {{3{heading_q[15]}}, heading_q};
    if (bdiff >= 19'sd46080) begin
      bmod = bdiff - 19'sd46080;
    end else if (bdiff <= -19'sd46080) begin
      bmod = bdiff + 19'sd46080;
    end else begin
      bmod = bdiff;
    end
    err_w = ahs_wrap_half(bmod);
  end

  // Rate difference, saturation and heading arithmetic.
  logic [19:0]        want;
  logic signed [21:0] swant, diff;
  logic [19:0]        sat;
  logic signed [38:0] hround;
  logic signed [23:0] hsum;
  logic signed [18:0] hmod;
  always_comb begin
    want   = sts_o.full ? mr_q : div_quot[19:0];
    swant  = err_q[15] ? -$signed({2'b0, want}) : $signed({2'b0, want});
    diff   = swant - {rate_q[20], rate_q};
    sat    = (div_quot > {18'd0, macc_q}) ? macc_q : div_quot[19:0];
    hround = $signed({prod_q[37], prod_q}) + 39'sd32768;
    hsum   = {{8{heading_q[15]}}, heading_q} + {hround[38], hround[38:16]};
    hmod   = sneg_q ? -$signed({3'd0, red_q[15:0]}) : $signed({3'd0, red_q[15:0]});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coin_q <= (dx == 17'sd0) && (dy == 17'sd0);
      ts_q   <= in_data_i.time_step;
      idx_q  <= '0;
      if (dx < 17'sd0) begin
        cx_q <= -x0;
        cy_q <= -y0;
        cz_q <= (dy >= 17'sd0) ? ZW'(Z_HALF) : -ZW'(Z_HALF);
      end else begin
        cx_q <= x0;
        cy_q <= y0;
        cz_q <= '0;
      end
    end
    if (cmd_i.cordic) begin
      idx_q <= idx_q + 1'b1;
      if (cy_q > 0) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end
    end
    if (cmd_i.calc_err) begin
      err_q  <= err_w;
      size_q <= err_w[15] ? 15'(-err_w) : err_w[14:0];
    end
    if (cmd_i.mul_want) begin
      prod_q <= 38'(mr_q * size_q);
    end
    if (cmd_i.calc_diff) begin
      dneg_q <= diff[21];
      dmag_q <= diff[21] ? 22'(-diff) : diff;
    end
    if (cmd_i.ang_zero) begin
      ang_q <= '0;
    end else if (cmd_i.sat) begin
      ang_q <= dneg_q ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end
    if (cmd_i.head_mul) begin
      prod_q <= 38'($signed(ang_q) * $signed({1'b0, ts_q}));
    end
    if (cmd_i.head_add) begin
      sneg_q <= hsum[23];
      smag_q <= hsum[23] ? 24'(-hsum) : hsum;
    end
    if (cmd_i.out_load) begin
      out_q.angular_out <= ang_q;
      out_q.new_heading <= heading_q;
      out_q.coincident  <= coin_q;
    end
  end

  // The new rate is taken with the multiply, the heading after its wrap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      rate_q    <= '0;
    end else begin
      if (cmd_i.head_mul) begin
        rate_q <= ang_q;
      end
      if (cmd_i.head_wrap) begin
        heading_q <= ahs_wrap_half(hmod);
      end
    end
  end

  assign sts_o.cordic_last = (idx_q == IW'(CORDIC_STEPS - 1));
  assign sts_o.coin        = coin_q;
  assign sts_o.in_radius   = size_q < tr_q;
  assign sts_o.full        = (sl_q == 15'd0) || (size_q > sl_q);
  assign sts_o.div_busy    = div_busy || red_busy_q;
  assign out_data_o        = out_q;

endmodule

[hdl/ahs_ctrl.sv]
// Controller: sequences one word through the datapath and owns both handshakes.
// Depends on ahs_pkg and the assertion macro header.
module ahs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ahs_pkg::sts_t sts_i,
  output ahs_pkg::cmd_t cmd_o
);
  import ahs_pkg::*;
  `include "align_heading_steering_core_assert.svh"

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_CORDIC;
      S_CORDIC: if (sts_i.cordic_last) state_d = S_ERR;
      S_ERR:    state_d = S_DECIDE;
      S_DECIDE: begin
        if (sts_i.coin || sts_i.in_radius) begin
          state_d = S_HMUL;
        end else if (sts_i.full) begin
          state_d = S_DIFF;
        end else begin
          state_d = S_MULW;
        end
      end
      S_MULW:   state_d = S_DIVW_S;
      S_DIVW_S: state_d = S_DIVW_W;
      S_DIVW_W: if (!sts_i.div_busy) state_d = S_DIFF;
      S_DIFF:   state_d = S_DIVA_S;
      S_DIVA_S: state_d = S_DIVA_W;
      S_DIVA_W: if (!sts_i.div_busy) state_d = S_SAT;
      S_SAT:    state_d = S_HMUL;
      S_HMUL:   state_d = S_HADD;
      S_HADD:   state_d = S_DIVH_S;
      S_DIVH_S: state_d = S_DIVH_W;
      S_DIVH_W: if (!sts_i.div_busy) state_d = S_HWRAP;
      S_HWRAP:  state_d = S_DONE;
      S_DONE:   if (can_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_WANT;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_CORDIC: cmd_o.cordic = 1'b1;
      S_ERR:    cmd_o.calc_err = 1'b1;
      S_DECIDE: cmd_o.ang_zero = sts_i.coin || sts_i.in_radius;
      S_MULW:   cmd_o.mul_want = 1'b1;
      S_DIVW_S: cmd_o.div_start = 1'b1;
      S_DIFF:   cmd_o.calc_diff = 1'b1;
      S_DIVA_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ANG;
      end
      S_SAT:    cmd_o.sat = 1'b1;
      S_HMUL:   cmd_o.head_mul = 1'b1;
      S_HADD:   cmd_o.head_add = 1'b1;
      S_DIVH_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_HEAD;
      end
      S_HWRAP:  cmd_o.head_wrap = 1'b1;
      S_DONE: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `AHS_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_CORDIC, "accepted word did not start the CORDIC")
  `AHS_ASSERT_NEXT(a_cordic_runs, state_q == S_CORDIC && !sts_i.cordic_last, state_q == S_CORDIC, "CORDIC left early")
  `AHS_ASSERT_NEXT(a_done_holds, state_q == S_DONE && out_valid_q && !out_ready_i, state_q == S_DONE, "result overwritten while held")
  `AHS_ASSERT_SAME(a_start_idle_div, cmd_o.div_start, !sts_i.div_busy, "divider started while busy")

endmodule

[hdl/align_heading_steering_core.sv]
// Heading steering core: one word per control tick, one result word per input word.
// A result is valid latest after its word is accepted when the wanted rate is scaled by
// the error, sooner at full wanted rate, and soonest when the positions coincide or the
// error is inside the target radius. The length is set by the CORDIC, one iteration per
// cycle, by the shared 38-bit divider, one quotient bit per cycle (up to two divisions per
// word), and by a reduction of the heading modulo a full turn. The core is ready for the
// next word from the cycle in which the previous result reaches the output register,
// which waits only while an earlier result is still held by the receiver.
module align_heading_steering_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [19:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ahs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ahs_pkg::out_t out_data_o
);
  import ahs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ahs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  ahs_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

[test/align_heading_steering_core_chk.sv]
`timescale 1ns / 1ps
// Scoreboard of the heading steering core: follows register writes and accepted words
// on both channels, predicts each result word and compares it. Depends on ahs_pkg.
module align_heading_steering_core_chk (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [19:0]   cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ahs_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ahs_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o
);
  import ahs_pkg::*;

  localparam int STEPS = 16;
  localparam longint TURN = 46080;
  localparam longint HALF = 23040;

  // Arctangent table in 1/32768 degree.
  localparam longint ATAN_LUT [16] = '{
    1474560, 870484, 459940, 233473, 117189, 58653, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57
  };

  longint head_q, rate_q;
  longint tgt_rad, slow_rad, max_rot, t_tgt, max_acc;
  out_t   expected_words[$];
  int     errors;

  assign errors_o  = errors;
  assign pending_o = expected_words.size();

  function automatic longint fold_angle(longint a);
    longint r;
    r = a % TURN;
    if (r > HALF) r = r - TURN;
    else if (r < -HALF) r = r + TURN;
    return r;
  endfunction

  // Vectoring rotation toward the x axis; the accumulated angle is the bearing.
  function automatic longint target_bearing(longint dx, longint dy);
    longint x, y, z, nx;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 32768 : -180 * 32768;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_LUT[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_LUT[i];
      end
      x = nx;
    end
    return (z + 128) >>> 8;
  endfunction

  // Computes the steering word of one tick and advances heading and rate.
  function automatic out_t steer_tick(in_t d);
    longint dx, dy, err, mag, want, dv, ang, delta;
    out_t r;
    dx = longint'(d.target_x) - longint'(d.self_x);
    dy = longint'(d.target_y) - longint'(d.self_y);
    ang = 0;
    r.coincident = 1'b0;
    if (dx == 0 && dy == 0) begin
      r.coincident = 1'b1;
    end else begin
      err = fold_angle(target_bearing(dx, dy) - head_q);
      mag = (err < 0) ? -err : err;
      if (mag >= tgt_rad) begin
        if (slow_rad == 0 || mag > slow_rad) want = max_rot;
        else want = (max_rot * mag) / slow_rad;
        if (err < 0) want = -want;
        dv  = (t_tgt == 0) ? 1 : t_tgt;
        ang = ((want - rate_q) * 65536) / dv;
        if (ang > max_acc) ang = max_acc;
        else if (ang < -max_acc) ang = -max_acc;
      end
    end
    rate_q = ang;
    delta  = (rate_q * longint'(d.time_step) + 32768) >>> 16;
    head_q = fold_angle(head_q + delta);
    r.angular_out = ang[20:0];
    r.new_heading = head_q[15:0];
    return r;
  endfunction

  // Track registers, predict on accepted input words, compare accepted result words.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want_w;
    if (!rst_ni) begin
      head_q   = 0;
      rate_q   = 0;
      tgt_rad  = 128;
      slow_rad = 1280;
      max_rot  = 11520;
      t_tgt    = 6554;
      max_acc  = 23040;
      errors   = 0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_TARGET_RADIUS: tgt_rad  = cfg_data_i[14:0];
          REG_SLOW_RADIUS:   slow_rad = cfg_data_i[14:0];
          REG_MAX_ROTATION:  max_rot  = cfg_data_i;
          REG_TIME_TO_TGT:   t_tgt    = cfg_data_i[15:0];
          REG_MAX_ACCEL:     max_acc  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(steer_tick(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, actual %h", $time, out_data_i);
          errors++;
        end else begin
          want_w = expected_words.pop_front();
          if (out_data_i.angular_out !== want_w.angular_out) begin
            $display("%0t: angular_out expected %0d actual %0d", $time,
                     want_w.angular_out, out_data_i.angular_out);
            errors++;
          end
          if (out_data_i.new_heading !== want_w.new_heading) begin
            $display("%0t: new_heading expected %0d actual %0d", $time,
                     want_w.new_heading, out_data_i.new_heading);
            errors++;
          end
          if (out_data_i.coincident !== want_w.coincident) begin
            $display("%0t: coincident expected %0d actual %0d", $time,
                     want_w.coincident, out_data_i.coincident);
            errors++;
          end
        end
      end
    end
  end

endmodule

[test/align_heading_steering_core_tb.sv]
`timescale 1ns / 1ps
// Top of the heading steering core testbench: clock, reset, register phases and
// input words; depends on ahs_pkg, the core and align_heading_steering_core_chk.
module align_heading_steering_core_tb;
  import ahs_pkg::*;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [19:0] cfg_data;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_t         in_data;
  out_t        out_data;
  int          errors, pending;
  bit          quiet;

  align_heading_steering_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  align_heading_steering_core_chk chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls in short random bursts until the quiet part of the run.
  int stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [19:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Waits for every result, lets the core settle, then loads all five registers.
  task automatic load_regs(int tr, int sr, int mr, int tt, int ma);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    write_reg(REG_TARGET_RADIUS, 20'(tr));
    write_reg(REG_SLOW_RADIUS, 20'(sr));
    write_reg(REG_MAX_ROTATION, 20'(mr));
    write_reg(REG_TIME_TO_TGT, 20'(tt));
    write_reg(REG_MAX_ACCEL, 20'(ma));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Presents one word, holds it until accepted, then maybe idles for a short burst.
  task automatic send_word(logic [15:0] tx, logic [15:0] ty, logic [15:0] sx,
                           logic [15:0] sy, logic [15:0] ts);
    in_valid <= 1'b1;
    in_data  <= '{tx, ty, sx, sy, ts};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic random_word();
    logic [15:0] sx, sy, tx, ty;
    int mode;
    sx = 16'($urandom);
    sy = 16'($urandom);
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      tx = sx;
      ty = sy;
    end else if (mode < 4) begin
      tx = sx + 16'($urandom_range(0, 400)) - 16'd200;
      ty = sy + 16'($urandom_range(0, 400)) - 16'd200;
    end else begin
      tx = 16'($urandom);
      ty = 16'($urandom);
    end
    send_word(tx, ty, sx, sy, ($urandom_range(0, 1)) ? 16'($urandom) :
              16'($urandom_range(0, 8192)));
  endtask

  initial begin
    quiet    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings.
    send_word(16'sd5, 16'sd7, 16'sd5, 16'sd7, 16'd1000);          // equal positions
    send_word(16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'd500);          // error inside radius
    send_word(16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'hFFFF);
    send_word(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'hFFFF);
    send_word(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd0);
    send_word(-16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'd3000);         // bearing on -x axis
    send_word(-16'sd100, -16'sd1, 16'sd0, 16'sd0, 16'd3000);
    send_word(16'sd0, -16'sd100, 16'sd0, 16'sd0, 16'd20000);
    send_word(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd65535);
    send_word(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'd1);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd65535);
    send_word(16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'd40000);

    // Extremes: zero radius, smallest slow radius, largest rates, fastest response.
    load_regs(0, 1, 20'hFFFFF, 1, 20'hFFFFF);
    for (int i = 0; i < 6; i++) send_word(16'(i * 9000), -16'(i * 7000), 16'sd0, 16'sd0,
                                          16'hFFFF);
    // Zero slow radius and zero time to target, small rates.
    load_regs(0, 0, 100, 0, 50);
    for (int i = 0; i < 4; i++) random_word();
    // Opposite extremes: target radius of a half turn, no rotation, no acceleration.
    load_regs(23040, 23040, 0, 65535, 0);
    for (int i = 0; i < 3; i++) random_word();

    // Random phases, the first under the reset settings, the rest with random settings in range.
    for (int p = 0; p < 8; p++) begin
      if (p == 0) load_regs(128, 1280, 11520, 6554, 23040);
      else load_regs($urandom_range(0, 2000), $urandom_range(1, 23040),
                     $urandom_range(0, 1048575), $urandom_range(1, 65535),
                     $urandom_range(0, 1048575));
      if (p == 7) quiet = 1'b1;
      for (int i = 0; i < 100; i++) begin
        random_word();
        // Sender holds off until the core has drained once per phase.
        if (i == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #8ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ahs_pkg.sv
hdl/ahs_divider.sv
hdl/ahs_datapath.sv
hdl/ahs_ctrl.sv
hdl/align_heading_steering_core.sv
test/align_heading_steering_core_chk.sv
test/align_heading_steering_core_tb.sv
